// ===== src/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Shared constants, register codes and the size clamp of the 3x3 max filter.
// ----------------------------------------------------------------------------
`default_nettype none

package smx_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int PIXEL_W  = 8;    // width of the pixel and result ports
  localparam int SIZE_W   = 11;   // width of the size registers
  localparam int CFG_AW   = 3;    // byte address, two 32-bit registers
  localparam int CFG_DW   = 32;
  localparam int SIZE_MIN = 3;
  localparam int SIZE_RST = 1024;

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Effective size: below three acts as three, above the given top acts as
  // the top.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int top);
    logic [SIZE_W-1:0] res;
    res = v;
    if (int'(v) < SIZE_MIN) begin
      res = SIZE_W'(SIZE_MIN);
    end else if (int'(v) > top) begin
      res = SIZE_W'(top);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/smx_line_buf.sv =====
// ----------------------------------------------------------------------------
// smx_line_buf
// Line store pair: one entry per column holds the pixels of the previous two
// rows. Registered read, one write port.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_line_buf #(
  parameter int DEPTH = 1024,
  parameter int DW    = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DW-1:0]            rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/sliding_max_3x3.sv =====
// ----------------------------------------------------------------------------
// sliding_max_3x3
// A result is loaded into the result register when its beat leaves stage 1.
// Throughput: one pixel per cycle unless the result channel stalls, set by
// one line-store read and write per beat; border pixels give no result beat.
// Reset (rst_n low, synchronous) empties the pipeline, zeroes the row and
// column counters and the column-max history, and sets both sizes to 1024.
// Line store contents are not cleared; no pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_max_3x3 #(
  parameter int MAX_WIDTH  = smx_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = smx_pkg::DEF_MAX_HEIGHT,
  parameter int PIXEL_BITS = smx_pkg::DEF_PIXEL_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // pixel input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [smx_pkg::PIXEL_W-1:0]   in_pixel_value,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [smx_pkg::PIXEL_W-1:0]   out_window_max,
  output logic                               out_row_end,
  output logic                               out_frame_end,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [smx_pkg::CFG_AW-1:0]    paddr,
  input  wire logic [smx_pkg::CFG_DW-1:0]    pwdata,
  output logic      [smx_pkg::CFG_DW-1:0]    prdata,
  output logic                               pready
);

  import smx_pkg::*;

  // Stored pixel width: bits above PIXEL_BITS are dropped, and the port
  // carries no more than PIXEL_W bits anyway.
  localparam int PB   = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  // Size registers are 11 bits, so WTOP and HTOP never exceed 2047.
  localparam int SIZE_TOP = (1 << SIZE_W) - 1;
  localparam int WTOP = (MAX_WIDTH  < SIZE_TOP) ? MAX_WIDTH  : SIZE_TOP;
  localparam int HTOP = (MAX_HEIGHT < SIZE_TOP) ? MAX_HEIGHT : SIZE_TOP;
  localparam int CCW  = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
  localparam int RCW  = ((RW > SIZE_W) ? RW : SIZE_W) + 1;
  localparam logic [SIZE_W-1:0] WRST = clamp_size(SIZE_W'(SIZE_RST), WTOP);
  localparam logic [SIZE_W-1:0] HRST = clamp_size(SIZE_W'(SIZE_RST), HTOP);

  // Stage-1 beat: the accepted pixel plus everything decided from the
  // position counters at accept time.
  typedef struct packed {
    logic [PB-1:0] pix;
    logic [CW-1:0] col;
    logic          emit;      // full window: row and column both >= 2
    logic          last_col;
    logic          last_row;
  } s1_t;

  // --------------------------------------------------------------------------
  // Configuration registers. They hold the clamped size; reads return it.
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0] width_r, width_nxt;
  logic [SIZE_W-1:0] height_r, height_nxt;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (cfg_reg_t'(paddr[2]))
        REG_IMAGE_WIDTH:  width_nxt  = clamp_size(pwdata[SIZE_W-1:0], WTOP);
        REG_IMAGE_HEIGHT: height_nxt = clamp_size(pwdata[SIZE_W-1:0], HTOP);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg_t'(paddr[2]))
      REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DW'(height_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WRST;
      height_r <= HRST;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage 1 drains into the result register; a border beat has
  // no result and leaves stage 1 whenever it is there.
  // --------------------------------------------------------------------------
  s1_t  s1_r, s1_nxt;
  logic s1_vld_r, s1_vld_nxt;
  logic s1_adv;
  logic in_acc;
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign s1_adv   = s1_vld_r && (!s1_r.emit || out_free);
  assign in_stall = s1_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Raster position. Column wraps at the last column; a position at or past
  // the size (size lowered mid-frame) counts as the last one.
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          last_col, last_row;

  assign last_col = (CCW'(col_r) + CCW'(1)) >= CCW'(width_r);
  assign last_row = (RCW'(row_r) + RCW'(1)) >= RCW'(height_r);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : RW'(row_r + 1'b1);
      end else begin
        col_nxt = CW'(col_r + 1'b1);
      end
    end
  end

  always_comb begin
    s1_nxt     = s1_r;
    s1_vld_nxt = s1_vld_r && !s1_adv;
    if (in_acc) begin
      s1_nxt.pix      = in_pixel_value[PB-1:0];
      s1_nxt.col      = col_r;
      s1_nxt.emit     = (col_r >= CW'(2)) && (row_r >= RW'(2));
      s1_nxt.last_col = last_col;
      s1_nxt.last_row = last_row;
      s1_vld_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // --------------------------------------------------------------------------
  // Line stores: read at accept, written back when the beat leaves stage 1.
  // Consecutive beats are always in different columns (size >= 3), so the
  // write-back never collides with the next read.
  // --------------------------------------------------------------------------
  logic [2*PB-1:0] lb_rd;
  logic [2*PB-1:0] lb_wr;
  logic [PB-1:0]   near_pix, far_pix;

  assign near_pix = lb_rd[2*PB-1:PB];
  assign far_pix  = lb_rd[PB-1:0];
  assign lb_wr    = {s1_r.pix, near_pix};   // shift: new -> near, near -> far

  smx_line_buf #(
    .DEPTH (MAX_WIDTH),
    .DW    (2*PB)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (lb_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_r.col),
    .wr_data (lb_wr)
  );

  // --------------------------------------------------------------------------
  // Column max of the three rows, then the window max with the two previous
  // column maxima.
  // --------------------------------------------------------------------------
  logic [PB-1:0] hist0_r, hist0_nxt;
  logic [PB-1:0] hist1_r, hist1_nxt;
  logic [PB-1:0] nf_max, col_max, hist_max, win_max;

  assign nf_max   = (near_pix > far_pix) ? near_pix : far_pix;
  assign col_max  = (s1_r.pix > nf_max) ? s1_r.pix : nf_max;
  assign hist_max = (hist0_r > hist1_r) ? hist0_r : hist1_r;
  assign win_max  = (col_max > hist_max) ? col_max : hist_max;

  always_comb begin
    hist0_nxt = hist0_r;
    hist1_nxt = hist1_r;
    if (s1_adv) begin
      hist0_nxt = col_max;
      hist1_nxt = hist0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
    end else begin
      hist0_r <= hist0_nxt;
      hist1_r <= hist1_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic               out_load;
  logic               out_vld_r, out_vld_nxt;
  logic [PIXEL_W-1:0] out_max_r;
  logic               out_row_end_r, out_frame_end_r;

  assign out_load    = s1_adv && s1_r.emit;
  assign out_vld_nxt = out_load || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_max_r       <= PIXEL_W'(win_max);
      out_row_end_r   <= s1_r.last_col;
      out_frame_end_r <= s1_r.last_col && s1_r.last_row;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_window_max = out_max_r;
  assign out_row_end    = out_row_end_r;
  assign out_frame_end  = out_frame_end_r;

endmodule

`default_nettype wire

// ===== src/smx_checker.sv =====
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks for the 3x3 max filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smx_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [smx_pkg::PIXEL_W-1:0] out_window_max,
  input  wire logic                        out_row_end,
  input  wire logic                        out_frame_end,
  input  wire logic                        pready
);

  // no result beat right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // last beat of a frame is also last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  // config port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

  // stalled result beat stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      $stable(out_window_max) && $stable(out_row_end) && $stable(out_frame_end))
    else $error("stalled result payload changed");

endmodule

bind sliding_max_3x3 smx_checker u_smx_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_sliding_max_3x3.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_max_3x3
// Self-checking bench for the streaming 3x3 max filter. A queue-fed driver
// sends pixel beats, a monitor takes result beats, and a scoreboard model of
// the line stores and column-max history predicts every window result. The
// run covers the size extremes, out-of-range sizes, size changes in the
// middle of a frame, back-pressure, and a long stretch of random frames.
// ----------------------------------------------------------------------------
module tb_sliding_max_3x3;
  timeunit 1ns;
  timeprecision 1ps;

  import smx_pkg::*;

  localparam int          HALF_PERIOD   = 1;
  localparam int          STORE_DEPTH   = 1024;      // deepest row the filter holds
  localparam int          ROW_LIMIT     = 1024;      // tallest frame
  localparam int          WIDE_SIZE     = 24;        // widest size the random phases use
  localparam int          MAX_GAP       = 14;        // longest idle draw per beat
  localparam int          LONG_HOLD     = 400;       // receiver hold-off in the fill test
  localparam int          SETTLE_CYCLES = 6;         // pipeline is two deep, plus margin
  localparam int          DRAIN_LIMIT   = 100000;    // cycles allowed to empty a phase
  localparam int          RANDOM_PIXELS = 320;
  localparam longint      TIMEOUT_NS    = 2000000;

  // Window result as the monitor expects it.
  typedef struct packed {
    logic [PIXEL_W-1:0] peak;
    logic               row_last;
    logic               frame_last;
  } window_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [PIXEL_W-1:0] in_pixel_value = '0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [PIXEL_W-1:0] out_window_max;
  logic               out_row_end;
  logic               out_frame_end;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [CFG_AW-1:0]  paddr          = '0;
  logic [CFG_DW-1:0]  pwdata         = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  // Pixels waiting to be sent and windows waiting to come back.
  logic [PIXEL_W-1:0] pixel_q [$];
  window_t            window_q [$];

  // Scoreboard copy of the filter: line stores, column-max history, raster
  // position and the effective (clamped) frame size.
  logic [PIXEL_W-1:0] near_row [STORE_DEPTH];
  logic [PIXEL_W-1:0] far_row  [STORE_DEPTH];
  logic [PIXEL_W-1:0] col_hist [2];
  int unsigned        col_pos    = 0;
  int unsigned        row_pos    = 0;
  int unsigned        eff_width  = STORE_DEPTH;
  int unsigned        eff_height = ROW_LIMIT;

  // Idle control: a calm side never idles.
  bit                 calm_send  = 1'b0;
  bit                 calm_recv  = 1'b0;
  bit                 hold_kick  = 1'b0;
  bit                 hold_seen;
  int                 hold_left;

  // Run statistics.
  int                 failures      = 0;
  int                 beats_in      = 0;
  int                 windows_out   = 0;
  int                 stalled_beats = 0;
  int                 size_writes   = 0;

  sliding_max_3x3 dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_window_max (out_window_max),
    .out_row_end    (out_row_end),
    .out_frame_end  (out_frame_end),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Scoreboard helpers
  // --------------------------------------------------------------------------
  function automatic logic [PIXEL_W-1:0] bigger(logic [PIXEL_W-1:0] a,
                                                logic [PIXEL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Size register to frame size: only SIZE_W bits are kept, then the value
  // is pinned into 3..top.
  function automatic int unsigned effective_size(int unsigned raw, int unsigned top);
    int unsigned v;
    v = raw % (1 << SIZE_W);
    if (v < 3) return 3;
    if (v > top) return top;
    return v;
  endfunction

  // Advance the filter by one accepted pixel; queue a window when the 3x3
  // neighborhood is complete (row and column both at least two).
  function automatic void filter_pixel(logic [PIXEL_W-1:0] px);
    int unsigned        slot;
    logic [PIXEL_W-1:0] near_px;
    logic [PIXEL_W-1:0] far_px;
    logic [PIXEL_W-1:0] col_peak;
    bit                 last_col;
    bit                 last_row;
    window_t            win;
    slot     = (col_pos < STORE_DEPTH) ? col_pos : STORE_DEPTH - 1;
    near_px  = near_row[slot];
    far_px   = far_row[slot];
    col_peak = bigger(px, bigger(near_px, far_px));
    // A position past the current size counts as the last column / row.
    last_col = (col_pos + 1) >= eff_width;
    last_row = (row_pos + 1) >= eff_height;
    if (col_pos >= 2 && row_pos >= 2) begin
      win.peak       = bigger(col_peak, bigger(col_hist[0], col_hist[1]));
      win.row_last   = last_col;
      win.frame_last = last_col && last_row;
      window_q.insert(window_q.size(), win);
    end
    far_row[slot]  = near_px;
    near_row[slot] = px;
    col_hist[1]    = col_hist[0];
    col_hist[0]    = col_peak;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  // Beats left until the current frame closes, from the present position.
  function automatic int unsigned pixels_to_frame_end();
    int unsigned row_px;
    int unsigned rows_after;
    row_px     = (col_pos + 1 >= eff_width) ? 1 : eff_width - col_pos;
    rows_after = (row_pos + 1 >= eff_height) ? 0 : eff_height - 1 - row_pos;
    return row_px + rows_after * eff_width;
  endfunction

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Mostly small frames; now and then a size below range or a wider one.
  function automatic int unsigned pick_size(int unsigned usual_top);
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return $urandom_range(0, 2);
    if (roll == 1) return $urandom_range(usual_top + 1, WIDE_SIZE);
    return $urandom_range(3, usual_top);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: one pixel beat per queue entry, a fresh idle draw after each beat.
  // The payload holds while in_stall is high; valid only drops when no beat
  // is ready.
  // --------------------------------------------------------------------------
  int send_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_pixel(in_pixel_value);
        beats_in++;
      end
      if (in_valid && in_stall) begin
        stalled_beats++;
      end
      if (!in_valid || !in_stall) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_pixel_value <= pixel_q.pop_front();
          in_valid       <= 1'b1;
          send_wait      = draw_gap(calm_send);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long receiver hold-off, counted here and started by toggling hold_kick.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= LONG_HOLD;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: takes result beats and checks them field by field against the
  // oldest predicted window, then stalls for a freshly drawn count.
  // --------------------------------------------------------------------------
  int recv_wait = 0;

  always @(posedge clk) begin
    window_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        windows_out++;
        if (window_q.size() == 0) begin
          $error("unexpected result beat: window_max %0d row_end %0b frame_end %0b",
                 out_window_max, out_row_end, out_frame_end);
          failures++;
        end else begin
          want = window_q.pop_front();
          if (out_window_max !== want.peak) begin
            $error("window_max: expected %0d, got %0d", want.peak, out_window_max);
            failures++;
          end
          if (out_row_end !== want.row_last) begin
            $error("row_end: expected %0b, got %0b", want.row_last, out_row_end);
            failures++;
          end
          if (out_frame_end !== want.frame_last) begin
            $error("frame_end: expected %0b, got %0b", want.frame_last, out_frame_end);
            failures++;
          end
        end
        recv_wait = draw_gap(calm_recv);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_stall <= (recv_wait > 0) || (hold_left > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer tasks. All queue traffic from here happens at the falling edge
  // so it never races the clocked driver and monitor.
  // --------------------------------------------------------------------------

  // Wait for every pixel to be taken and every window to come back, then
  // let the pipeline run dry (border pixels leave no result to wait on).
  task automatic settle();
    int guard;
    guard = 0;
    while ((pixel_q.size() > 0 || in_valid || window_q.size() > 0) && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    if (guard >= DRAIN_LIMIT) begin
      $error("results never arrived: %0d windows still expected", window_q.size());
      failures++;
      window_q.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Size register write: setup cycle, then access until pready. The
  // register is then read back and must hold the clamped size.
  task automatic write_size(cfg_reg_t which, int unsigned value);
    int unsigned want_size;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(4 * int'(which));
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (which == REG_IMAGE_WIDTH) begin
      eff_width = effective_size(value, STORE_DEPTH);
      want_size = eff_width;
    end else begin
      eff_height = effective_size(value, ROW_LIMIT);
      want_size  = eff_height;
    end
    size_writes++;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DW'(want_size)) begin
      $error("%s: expected %0d, got %0d",
             (which == REG_IMAGE_WIDTH) ? "image_width" : "image_height",
             want_size, prdata);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic queue_random(int unsigned count);
    repeat (count) pixel_q.insert(pixel_q.size(), PIXEL_W'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [PIXEL_W-1:0] corner_frame [9];
    int unsigned        random_pixels;
    int unsigned        count;
    int unsigned        roll;

    // Max in the top-left corner, so it has to travel through both line
    // stores and the whole column history to reach the single window.
    corner_frame = '{8'hC3, 8'h00, 8'h55, 8'hAA, 8'h0F, 8'h3C, 8'h01, 8'h80, 8'h7E};
    random_pixels = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      near_row[i] = '0;
      far_row[i]  = '0;
    end
    col_hist[0] = '0;
    col_hist[1] = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Sizes below range act as three: one 3x3 frame, one window with both
    // end marks. Both sides run without idling here.
    calm_send = 1'b1;
    calm_recv = 1'b1;
    write_size(REG_IMAGE_WIDTH, 0);
    write_size(REG_IMAGE_HEIGHT, 2);
    foreach (corner_frame[i]) pixel_q.insert(pixel_q.size(), corner_frame[i]);
    settle();

    // Width above range reads back as the store depth. Then the widest
    // random size: every line-store entry it can reach gets written, so
    // later size changes in the middle of a frame read only known data.
    calm_send = 1'b0;
    calm_recv = 1'b0;
    write_size(REG_IMAGE_WIDTH, 2047);
    write_size(REG_IMAGE_WIDTH, WIDE_SIZE);
    write_size(REG_IMAGE_HEIGHT, 3);
    queue_random(pixels_to_frame_end());
    settle();

    // Width below range, height above range: ten rows, then the height
    // drops to three, so the row in progress is the last one.
    write_size(REG_IMAGE_WIDTH, 1);
    write_size(REG_IMAGE_HEIGHT, 2047);
    queue_random(30);
    settle();
    write_size(REG_IMAGE_HEIGHT, 3);
    queue_random(pixels_to_frame_end());
    settle();

    // Size change mid-frame: stop at column 4 of row 2 in a 6x5 frame,
    // shrink to width 3 (column 4 now ends the row), stop again in row 3,
    // then shrink to height 3 (row 3 is now last, so the frame closes).
    write_size(REG_IMAGE_WIDTH, 6);
    write_size(REG_IMAGE_HEIGHT, 5);
    queue_random(16);
    settle();
    write_size(REG_IMAGE_WIDTH, 3);
    queue_random(3);
    settle();
    write_size(REG_IMAGE_HEIGHT, 3);
    queue_random(1);
    settle();

    // Fill test: the receiver runs a long hold-off (LONG_HOLD) while the sender
    // keeps offering a 12x12 frame back to back, so the block must push
    // back on its input. settle() then waits until every window has come back.
    calm_send = 1'b1;
    write_size(REG_IMAGE_WIDTH, 12);
    write_size(REG_IMAGE_HEIGHT, 12);
    hold_kick = ~hold_kick;
    queue_random(pixels_to_frame_end());
    settle();

    // Random frames. Most phases close the current frame (sometimes plus
    // one more); about a quarter stop at a random point so the next size
    // write lands mid-frame. Idling is redrawn per phase per side.
    while (random_pixels < RANDOM_PIXELS) begin
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 7);
      if (roll != 0) write_size(REG_IMAGE_WIDTH, pick_size(9));
      if (roll != 1) write_size(REG_IMAGE_HEIGHT, pick_size(7));
      if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, eff_width * eff_height);
      end else begin
        count = pixels_to_frame_end() + eff_width * eff_height * $urandom_range(0, 1);
      end
      if (count > RANDOM_PIXELS - random_pixels) begin
        count = RANDOM_PIXELS - random_pixels;
      end
      queue_random(count);
      random_pixels += count;
      settle();
    end

    $display("run covered %0d pixel beats and %0d window beats over %0d size writes",
             beats_in, windows_out, size_writes);
    $display("input held off by the block on %0d cycles", stalled_beats);
    if (failures == 0) begin
      $display("sliding_max_3x3 verification clean");
    end else begin
      $display("sliding_max_3x3 verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #(TIMEOUT_NS);
    $display("sliding_max_3x3 verification failed");
    $finish;
  end

endmodule
